[design/mfbs_pkg.sv]
// ----------------------------------------------------------------------------
// mfbs_pkg
// Shared types and constants of the frame boundary scanner.
// ----------------------------------------------------------------------------
package mfbs_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int COUNT_BITS_DEFAULT    = 24;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [31:0] MAX_PIXELS_RESET  = 32'd250000000;
    localparam logic [23:0] MAX_FRAMES_RESET  = 24'd1000000;
    localparam logic [39:0] MAX_SAMPLES_RESET = 40'd1000000000;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_MAX_PIXELS  = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAMES  = 2'd1;
    localparam logic [1:0] CFG_MAX_SAMPLES = 2'd2;

    // Marker codes.
    localparam logic [7:0] MRK_SOI  = 8'hd8;
    localparam logic [7:0] MRK_EOI  = 8'hd9;
    localparam logic [7:0] MRK_SOS  = 8'hda;
    localparam logic [7:0] MRK_SOF0 = 8'hc0;
    localparam logic [7:0] MRK_SOF1 = 8'hc1;
    localparam logic [7:0] MRK_SOF2 = 8'hc2;
    localparam logic [7:0] MRK_RST0 = 8'hd0;
    localparam logic [7:0] MRK_RST7 = 8'hd7;
    localparam logic [7:0] MRK_TEM  = 8'h01;

    // Result kinds.
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Status codes.
    localparam logic [4:0] ST_OK            = 5'd0;
    localparam logic [4:0] ST_EMPTY         = 5'd1;
    localparam logic [4:0] ST_NO_SOI        = 5'd2;
    localparam logic [4:0] ST_NO_EOI        = 5'd3;
    localparam logic [4:0] ST_NOT_MARKER    = 5'd4;
    localparam logic [4:0] ST_STUFF_OUTSIDE = 5'd5;
    localparam logic [4:0] ST_EOI_NO_HEADER = 5'd6;
    localparam logic [4:0] ST_NESTED_SOI    = 5'd7;
    localparam logic [4:0] ST_BAD_LENGTH    = 5'd8;
    localparam logic [4:0] ST_BAD_HEADER    = 5'd9;
    localparam logic [4:0] ST_UNSUPPORTED   = 5'd10;
    localparam logic [4:0] ST_PIXEL_LIMIT   = 5'd11;
    localparam logic [4:0] ST_FRAME_LIMIT   = 5'd12;
    localparam logic [4:0] ST_GEOMETRY      = 5'd13;
    localparam logic [4:0] ST_SAMPLE_LIMIT  = 5'd14;
    localparam logic [4:0] ST_END_AFTER_FF  = 5'd15;
    localparam logic [4:0] ST_END_IN_MARKER = 5'd16;
    localparam logic [4:0] ST_END_IN_LENGTH = 5'd17;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  status;
        logic [23:0] frame_index;
        logic [31:0] frame_offset;
        logic [31:0] frame_size;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  channels;
        logic [23:0] frame_count;
    } out_item_t;

    // A request after classification.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       is_ff;
        logic       is_zero;
        logic       is_rst;
        logic       is_tem;
        logic       is_soi;
        logic       is_eoi;
    } byte_class_t;

    typedef struct packed {
        logic [31:0] max_pixels;
        logic [23:0] max_frames;
        logic [39:0] max_samples;
    } limits_t;

    function automatic logic is_frame_header(input logic [7:0] m);
        return (m == MRK_SOF0) || (m == MRK_SOF1) || (m == MRK_SOF2);
    endfunction

endpackage

[design/mfbs_front.sv]
// ----------------------------------------------------------------------------
// mfbs_front
// Input stage: registers each request and decodes the byte classes.
// ----------------------------------------------------------------------------
module mfbs_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mfbs_pkg::in_item_t    in_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mfbs_pkg::byte_class_t push_data
);

    logic                  valid_reg;
    logic                  valid_next;
    mfbs_pkg::byte_class_t class_reg;
    mfbs_pkg::byte_class_t class_next;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = class_reg;

    always_comb
    begin
        class_next.cmd       = in_data.cmd;
        class_next.data_byte = in_data.data_byte;
        class_next.is_ff     = (in_data.data_byte == 8'hff);
        class_next.is_zero   = (in_data.data_byte == 8'h00);
        class_next.is_rst    = (in_data.data_byte >= mfbs_pkg::MRK_RST0) &&
                               (in_data.data_byte <= mfbs_pkg::MRK_RST7);
        class_next.is_tem    = (in_data.data_byte == mfbs_pkg::MRK_TEM);
        class_next.is_soi    = (in_data.data_byte == mfbs_pkg::MRK_SOI);
        class_next.is_eoi    = (in_data.data_byte == mfbs_pkg::MRK_EOI);
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            class_reg <= class_next;
        end
    end

endmodule

[design/mfbs_queue.sv]
// ----------------------------------------------------------------------------
// mfbs_queue
// Short queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module mfbs_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  mfbs_pkg::byte_class_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output mfbs_pkg::byte_class_t pop_data
);

    localparam int PTR_BITS = $clog2(mfbs_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(mfbs_pkg::QUEUE_DEPTH + 1);

    mfbs_pkg::byte_class_t mem [mfbs_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != CNT_BITS'(mfbs_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(mfbs_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(mfbs_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/mfbs_back.sv]
// ----------------------------------------------------------------------------
// mfbs_back
// Parser: walks the marker structure, checks headers and limits, and
// drives the registered result.
// ----------------------------------------------------------------------------
module mfbs_back
#(
    parameter int POSITION_BITS = mfbs_pkg::POSITION_BITS_DEFAULT,
    parameter int COUNT_BITS    = mfbs_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfbs_pkg::limits_t     limits,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  mfbs_pkg::byte_class_t item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mfbs_pkg::out_item_t   out_data
);

    typedef enum logic [2:0] {
        SOI0,
        SOI1,
        MARKER,
        LEN_HI,
        LEN_LO,
        PAYLOAD,
        ENTROPY
    } mode_t;

    mode_t                     mode_reg, mode_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  start_reg, start_next;
    logic [15:0]               remain_reg, remain_next;
    logic [7:0]                seg_marker_reg, seg_marker_next;
    logic [7:0]                len_hi_reg, len_hi_next;
    logic [7:0]                prec_reg, prec_next;
    logic [15:0]               hdr_w_reg, hdr_w_next;
    logic [15:0]               hdr_h_reg, hdr_h_next;
    logic [7:0]                hdr_ch_reg, hdr_ch_next;
    logic                      seen_reg, seen_next;
    logic                      pff_reg, pff_next;
    logic [2:0]                cap_reg, cap_next;
    logic [COUNT_BITS-1:0]     frames_reg, frames_next;
    logic [15:0]               first_w_reg, first_w_next;
    logic [15:0]               first_h_reg, first_h_next;
    logic [7:0]                first_ch_reg, first_ch_next;
    logic [31:0]               area_reg, area_next;
    logic [33:0]               samples_reg, samples_next;
    logic [40:0]               total_reg, total_next;
    logic [4:0]                error_reg, error_next;
    logic                      out_valid_reg, out_valid_next;
    mfbs_pkg::out_item_t       out_reg, out_next;

    logic                      pop;
    logic                      load;
    logic [4:0]                err;
    logic                      do_end;
    logic                      do_marker;
    logic                      do_finish;
    logic [2:0]                cap_eff;
    logic [15:0]               seg_len;
    logic [41:0]               sum;
    logic [POSITION_BITS-1:0]  got;
    logic [4:0]                eos_status;
    logic [7:0]                b;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign b         = item.data_byte;
    assign seg_len   = {len_hi_reg, b};
    assign got       = pos_reg - start_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;
        remain_next     = remain_reg;
        seg_marker_next = seg_marker_reg;
        len_hi_next     = len_hi_reg;
        prec_next       = prec_reg;
        hdr_w_next      = hdr_w_reg;
        hdr_h_next      = hdr_h_reg;
        hdr_ch_next     = hdr_ch_reg;
        seen_next       = seen_reg;
        pff_next        = pff_reg;
        cap_next        = cap_reg;
        frames_next     = frames_reg;
        first_w_next    = first_w_reg;
        first_h_next    = first_h_reg;
        first_ch_next   = first_ch_reg;
        area_next       = area_reg;
        samples_next    = samples_reg;
        total_next      = total_reg;
        error_next      = error_reg;
        out_next        = out_reg;
        load            = 1'b0;
        err             = mfbs_pkg::ST_OK;
        do_end          = 1'b0;
        do_marker       = 1'b0;
        do_finish       = 1'b0;
        cap_eff         = 3'd0;
        sum             = {1'b0, total_reg} + 42'(samples_reg);

        // Truncation status for the end of stream summary.
        eos_status = error_reg;
        if (error_reg == mfbs_pkg::ST_OK)
        begin
            if (mode_reg == SOI0)
            begin
                eos_status = (frames_reg == '0) ? mfbs_pkg::ST_EMPTY : mfbs_pkg::ST_OK;
            end
            else if (got < POSITION_BITS'(4) || mode_reg == SOI1)
            begin
                eos_status = mfbs_pkg::ST_NO_SOI;
            end
            else if (mode_reg == MARKER)
            begin
                eos_status = pff_reg ? mfbs_pkg::ST_END_IN_MARKER : mfbs_pkg::ST_NO_EOI;
            end
            else if (mode_reg == LEN_HI || mode_reg == LEN_LO)
            begin
                eos_status = mfbs_pkg::ST_END_IN_LENGTH;
            end
            else if (mode_reg == PAYLOAD)
            begin
                eos_status = mfbs_pkg::ST_BAD_LENGTH;
            end
            else
            begin
                eos_status = pff_reg ? mfbs_pkg::ST_END_AFTER_FF : mfbs_pkg::ST_NO_EOI;
            end
        end

        if (pop && item.cmd)
        begin
            load                  = 1'b1;
            out_next.kind         = mfbs_pkg::KIND_SUMMARY;
            out_next.status       = eos_status;
            out_next.frame_index  = '0;
            out_next.frame_offset = '0;
            out_next.frame_size   = 32'(pos_reg);
            out_next.width        = first_w_reg;
            out_next.height       = first_h_reg;
            out_next.channels     = first_ch_reg[1:0];
            out_next.frame_count  = 24'(frames_reg);
            mode_next     = SOI0;
            pos_next      = '0;
            start_next    = '0;
            remain_next   = '0;
            seg_marker_next = '0;
            len_hi_next   = '0;
            prec_next     = '0;
            hdr_w_next    = '0;
            hdr_h_next    = '0;
            hdr_ch_next   = '0;
            seen_next     = 1'b0;
            pff_next      = 1'b0;
            cap_next      = '0;
            frames_next   = '0;
            first_w_next  = '0;
            first_h_next  = '0;
            first_ch_next = '0;
            total_next    = '0;
            error_next    = mfbs_pkg::ST_OK;
        end
        else if (pop)
        begin
            pos_next = pos_reg + 1'b1;
            if (error_reg == mfbs_pkg::ST_OK)
            begin
                unique case (mode_reg)
                    SOI0:
                    begin
                        start_next = pos_reg;
                        if (32'(frames_reg) >= 32'(limits.max_frames) || (&frames_reg))
                        begin
                            err = mfbs_pkg::ST_FRAME_LIMIT;
                        end
                        else if (!item.is_ff)
                        begin
                            err = mfbs_pkg::ST_NO_SOI;
                        end
                        else
                        begin
                            seen_next = 1'b0;
                            mode_next = SOI1;
                        end
                    end
                    SOI1:
                    begin
                        if (!item.is_soi)
                        begin
                            err = mfbs_pkg::ST_NO_SOI;
                        end
                        else
                        begin
                            mode_next = MARKER;
                            pff_next  = 1'b0;
                        end
                    end
                    MARKER:
                    begin
                        if (!pff_reg)
                        begin
                            if (!item.is_ff)
                            begin
                                err = mfbs_pkg::ST_NOT_MARKER;
                            end
                            else
                            begin
                                pff_next = 1'b1;
                            end
                        end
                        else if (item.is_zero)
                        begin
                            err = mfbs_pkg::ST_STUFF_OUTSIDE;
                        end
                        else if (!item.is_ff)
                        begin
                            do_marker = 1'b1;
                        end
                    end
                    LEN_HI:
                    begin
                        len_hi_next = b;
                        mode_next   = LEN_LO;
                    end
                    LEN_LO:
                    begin
                        if (seg_len < 16'd2)
                        begin
                            err = mfbs_pkg::ST_BAD_LENGTH;
                        end
                        else
                        begin
                            remain_next = seg_len - 16'd2;
                            cap_next    = '0;
                            cap_eff     = '0;
                            if (seg_len == 16'd2)
                            begin
                                do_end = 1'b1;
                            end
                            else
                            begin
                                mode_next = PAYLOAD;
                            end
                        end
                    end
                    PAYLOAD:
                    begin
                        if (mfbs_pkg::is_frame_header(seg_marker_reg) && !seen_reg &&
                            cap_reg < 3'd6)
                        begin
                            case (cap_reg)
                                3'd0: prec_next = b;
                                3'd1: hdr_h_next = {b, 8'h00};
                                3'd2: hdr_h_next = {hdr_h_reg[15:8], b};
                                3'd3: hdr_w_next = {b, 8'h00};
                                3'd4:
                                begin
                                    hdr_w_next = {hdr_w_reg[15:8], b};
                                    // Pixel count is registered before the segment can end.
                                    area_next  = hdr_h_reg * {hdr_w_reg[15:8], b};
                                end
                                default: hdr_ch_next = b;
                            endcase
                        end
                        cap_next    = (cap_reg < 3'd6) ? cap_reg + 1'b1 : cap_reg;
                        cap_eff     = cap_next;
                        remain_next = remain_reg - 1'b1;
                        if (remain_next == '0)
                        begin
                            do_end = 1'b1;
                        end
                    end
                    ENTROPY:
                    begin
                        if (!pff_reg)
                        begin
                            if (item.is_ff)
                            begin
                                pff_next = 1'b1;
                            end
                        end
                        else if (item.is_zero || item.is_rst)
                        begin
                            pff_next = 1'b0;
                        end
                        else if (!item.is_ff)
                        begin
                            do_marker = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = SOI0;
                    end
                endcase

                if (do_end)
                begin
                    if (mfbs_pkg::is_frame_header(seg_marker_reg))
                    begin
                        if (seen_reg || cap_eff < 3'd6)
                        begin
                            err = mfbs_pkg::ST_BAD_HEADER;
                        end
                        else if (prec_next != 8'd8 || hdr_w_next == '0 || hdr_h_next == '0 ||
                                 (hdr_ch_next != 8'd1 && hdr_ch_next != 8'd3))
                        begin
                            err = mfbs_pkg::ST_UNSUPPORTED;
                        end
                        else if (area_reg > limits.max_pixels)
                        begin
                            err = mfbs_pkg::ST_PIXEL_LIMIT;
                        end
                        else
                        begin
                            seen_next    = 1'b1;
                            samples_next = (hdr_ch_next == 8'd3) ?
                                           {1'b0, area_reg, 1'b0} + {2'b00, area_reg} :
                                           {2'b00, area_reg};
                        end
                    end
                    if (err == mfbs_pkg::ST_OK)
                    begin
                        mode_next = (seg_marker_reg == mfbs_pkg::MRK_SOS) ? ENTROPY : MARKER;
                        pff_next  = 1'b0;
                    end
                end

                if (do_marker)
                begin
                    pff_next = 1'b0;
                    if (item.is_eoi)
                    begin
                        if (!seen_reg)
                        begin
                            err = mfbs_pkg::ST_EOI_NO_HEADER;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                        end
                    end
                    else if (item.is_soi)
                    begin
                        err = mfbs_pkg::ST_NESTED_SOI;
                    end
                    else if (item.is_tem || item.is_rst)
                    begin
                        mode_next = MARKER;
                    end
                    else
                    begin
                        seg_marker_next = b;
                        mode_next       = LEN_HI;
                    end
                end

                if (do_finish)
                begin
                    if (frames_reg != '0 && (hdr_w_reg != first_w_reg ||
                        hdr_h_reg != first_h_reg || hdr_ch_reg != first_ch_reg))
                    begin
                        err = mfbs_pkg::ST_GEOMETRY;
                    end
                    else
                    begin
                        total_next = sum[41] ? '1 : sum[40:0];
                        if (total_next > {1'b0, limits.max_samples})
                        begin
                            err = mfbs_pkg::ST_SAMPLE_LIMIT;
                        end
                        else
                        begin
                            if (frames_reg == '0)
                            begin
                                first_w_next  = hdr_w_reg;
                                first_h_next  = hdr_h_reg;
                                first_ch_next = hdr_ch_reg;
                            end
                            load                  = 1'b1;
                            out_next.kind         = mfbs_pkg::KIND_FRAME;
                            out_next.status       = mfbs_pkg::ST_OK;
                            out_next.frame_index  = 24'(frames_reg);
                            out_next.frame_offset = 32'(start_reg);
                            out_next.frame_size   = 32'(pos_reg + 1'b1 - start_reg);
                            out_next.width        = hdr_w_reg;
                            out_next.height       = hdr_h_reg;
                            out_next.channels     = hdr_ch_reg[1:0];
                            out_next.frame_count  = 24'(frames_reg + 1'b1);
                            frames_next           = frames_reg + 1'b1;
                            mode_next             = SOI0;
                            pff_next              = 1'b0;
                        end
                    end
                end

                if (err != mfbs_pkg::ST_OK)
                begin
                    error_next            = err;
                    load                  = 1'b1;
                    out_next.kind         = mfbs_pkg::KIND_ERROR;
                    out_next.status       = err;
                    out_next.frame_index  = 24'(frames_reg);
                    out_next.frame_offset = 32'(start_next);
                    out_next.frame_size   = 32'(pos_reg + 1'b1 - start_next);
                    out_next.width        = '0;
                    out_next.height       = '0;
                    out_next.channels     = '0;
                    out_next.frame_count  = 24'(frames_reg);
                end
            end
        end

        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= SOI0;
            pos_reg        <= '0;
            start_reg      <= '0;
            remain_reg     <= '0;
            seg_marker_reg <= '0;
            len_hi_reg     <= '0;
            prec_reg       <= '0;
            hdr_w_reg      <= '0;
            hdr_h_reg      <= '0;
            hdr_ch_reg     <= '0;
            seen_reg       <= 1'b0;
            pff_reg        <= 1'b0;
            cap_reg        <= '0;
            frames_reg     <= '0;
            first_w_reg    <= '0;
            first_h_reg    <= '0;
            first_ch_reg   <= '0;
            area_reg       <= '0;
            samples_reg    <= '0;
            total_reg      <= '0;
            error_reg      <= mfbs_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            remain_reg     <= remain_next;
            seg_marker_reg <= seg_marker_next;
            len_hi_reg     <= len_hi_next;
            prec_reg       <= prec_next;
            hdr_w_reg      <= hdr_w_next;
            hdr_h_reg      <= hdr_h_next;
            hdr_ch_reg     <= hdr_ch_next;
            seen_reg       <= seen_next;
            pff_reg        <= pff_next;
            cap_reg        <= cap_next;
            frames_reg     <= frames_next;
            first_w_reg    <= first_w_next;
            first_h_reg    <= first_h_next;
            first_ch_reg   <= first_ch_next;
            area_reg       <= area_next;
            samples_reg    <= samples_next;
            total_reg      <= total_next;
            error_reg      <= error_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // Once an error is latched, stream bytes produce no further results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !item.cmd && error_reg != mfbs_pkg::ST_OK) |-> !load)
        else $error("result produced after a sticky error");

    // Every stream byte advances the position by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !item.cmd) |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("stream position did not advance");

    // End of stream clears the error and returns to the start of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.cmd) |=> (error_reg == mfbs_pkg::ST_OK && mode_reg == SOI0 &&
                               out_valid_reg))
        else $error("end of stream did not restart the parser");

endmodule

[design/mjpeg_frame_boundary_scanner.sv]
// ----------------------------------------------------------------------------
// mjpeg_frame_boundary_scanner
// Finds frame boundaries in a concatenated JPEG byte stream and checks limits.
// ----------------------------------------------------------------------------
// Throughput: one stream byte per clock cycle while out_ready does not hold the result output.
// Path: each byte is held in the front register, then written into the queue, and
// its result is driven from the parser output register.
// Reset: rst_n clears all parser state and restores the limit registers to
// their default values; no clearing pass is needed.
module mjpeg_frame_boundary_scanner
#(
    parameter int POSITION_BITS = mfbs_pkg::POSITION_BITS_DEFAULT,
    parameter int COUNT_BITS    = mfbs_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mfbs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mfbs_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [39:0]         cfg_data
);

    mfbs_pkg::limits_t     limits_reg;
    logic                  push_valid;
    logic                  push_ready;
    mfbs_pkg::byte_class_t push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    mfbs_pkg::byte_class_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_pixels  <= mfbs_pkg::MAX_PIXELS_RESET;
            limits_reg.max_frames  <= mfbs_pkg::MAX_FRAMES_RESET;
            limits_reg.max_samples <= mfbs_pkg::MAX_SAMPLES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mfbs_pkg::CFG_MAX_PIXELS:  limits_reg.max_pixels  <= cfg_data[31:0];
                mfbs_pkg::CFG_MAX_FRAMES:  limits_reg.max_frames  <= cfg_data[23:0];
                mfbs_pkg::CFG_MAX_SAMPLES: limits_reg.max_samples <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mfbs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mfbs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mfbs_back
    #(
        .POSITION_BITS (POSITION_BITS),
        .COUNT_BITS    (COUNT_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .limits    (limits_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .item      (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
